@@ src/five_bit_code_unpacker_defines.svh @@
// assertion macros used by the code unpacker top level
`ifndef FIVE_BIT_CODE_UNPACKER_DEFINES_SVH
`define FIVE_BIT_CODE_UNPACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FBCU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FBCU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/fbcu_pkg.sv @@
// types and constants of the five bit code unpacker
package fbcu_pkg;

	localparam int OPC_W    = 2;
	localparam int TABLE_AW = 5;
	localparam int CHAR_W   = 8;
	localparam int BYTE_W   = 8;

	// code value that terminates the stream
	localparam logic [7:0] END_CODE = 8'd31;

	typedef enum logic [OPC_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_DATA    = 2'd1,
		OP_RESTART = 2'd2
	} opcode_t;

	// one unpacked code waiting for its table lookup
	typedef struct packed {
		logic                term;
		logic [TABLE_AW-1:0] index;
	} code_entry_t;

	// decoder state update requests
	typedef struct packed {
		logic data_go;
		logic restart_go;
	} dec_ctrl_t;

endpackage

@@ src/fbcu_item_if.sv @@
// input channel: commands, table loads and packed data bytes
interface fbcu_item_if;
	logic                           valid;
	logic                           ready;
	logic [fbcu_pkg::OPC_W-1:0]     opcode;
	logic [fbcu_pkg::TABLE_AW-1:0]  table_index;
	logic [fbcu_pkg::CHAR_W-1:0]    table_value;
	logic [fbcu_pkg::BYTE_W-1:0]    data_byte;

	modport source (output valid, opcode, table_index, table_value, data_byte, input ready);
	modport sink   (input valid, opcode, table_index, table_value, data_byte, output ready);
endinterface

@@ src/fbcu_result_if.sv @@
// output channel: decoded characters and end marker
interface fbcu_result_if;
	logic                         valid;
	logic                         ready;
	logic [fbcu_pkg::CHAR_W-1:0]  out_char;
	logic                         end_mark;
	logic                         last;

	modport source (output valid, out_char, end_mark, last, input ready);
	modport sink   (input valid, out_char, end_mark, last, output ready);
endinterface

@@ src/fbcu_table.sv @@
// 32-entry character table, one write port and one registered read port
module fbcu_table (
	input  logic                           clk,
	input  logic                           we,
	input  logic [fbcu_pkg::TABLE_AW-1:0]  waddr,
	input  logic [fbcu_pkg::CHAR_W-1:0]    wdata,
	input  logic                           re,
	input  logic [fbcu_pkg::TABLE_AW-1:0]  raddr,
	output logic [fbcu_pkg::CHAR_W-1:0]    rdata
);

	localparam int DEPTH = 2 ** fbcu_pkg::TABLE_AW;

	logic [fbcu_pkg::CHAR_W-1:0] mem_q [DEPTH];
	logic [fbcu_pkg::CHAR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/fbcu_decode.sv @@
// splits a data byte plus leftover bits into codes, holds the bit carry state
module fbcu_decode #(
	parameter int CODE_BITS = 5,
	parameter int MAX_CODES = 2,
	parameter int LV_W      = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fbcu_pkg::dec_ctrl_t                ctrl,
	input  logic [fbcu_pkg::BYTE_W-1:0]        data_byte,
	output fbcu_pkg::code_entry_t [MAX_CODES-1:0] lanes,
	output logic [LV_W-1:0]                    count,
	output logic                               ended
);

	localparam int LB_W  = CODE_BITS - 1;
	localparam int LC_W  = $clog2(CODE_BITS);
	localparam int CNT_W = $clog2(CODE_BITS + fbcu_pkg::BYTE_W);
	localparam int ACC_W = LB_W + fbcu_pkg::BYTE_W;

	logic [LB_W-1:0]      lbits_q;
	logic [LC_W-1:0]      lcount_q;
	logic                 ended_q;

	logic [CNT_W-1:0]     cnt;
	logic [ACC_W-1:0]     acc;
	logic [CODE_BITS-1:0] lane_code [MAX_CODES];
	logic [MAX_CODES-1:0] lane_avail;
	logic                 stop;
	logic [CNT_W-1:0]     rem;
	logic [ACC_W-1:0]     rem_mask;

	assign cnt = CNT_W'(lcount_q) + CNT_W'(fbcu_pkg::BYTE_W);
	assign acc = {lbits_q, data_byte};

	// every lane extracts its code at a fixed offset from the top of the bits
	always_comb begin
		for (int k = 0; k < MAX_CODES; k++) begin
			lane_avail[k] = cnt >= CNT_W'((k + 1) * CODE_BITS);
			lane_code[k]  = CODE_BITS'(acc >> (cnt - CNT_W'((k + 1) * CODE_BITS)));
		end
	end

	// keep lanes up to and including the first terminator
	always_comb begin
		lanes = '0;
		count = '0;
		stop  = 1'b0;
		rem   = cnt;
		for (int k = 0; k < MAX_CODES; k++) begin
			if (lane_avail[k] && !stop) begin
				lanes[k].index = fbcu_pkg::TABLE_AW'(lane_code[k]);
				lanes[k].term  = 8'(lane_code[k]) == fbcu_pkg::END_CODE;
				count          = LV_W'(k + 1);
				stop           = lanes[k].term;
				rem            = stop ? '0 : cnt - CNT_W'((k + 1) * CODE_BITS);
			end
		end
	end

	assign rem_mask = (ACC_W'(1) << rem) - ACC_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbits_q  <= '0;
			lcount_q <= '0;
			ended_q  <= 1'b0;
		end else if (ctrl.restart_go) begin
			lbits_q  <= '0;
			lcount_q <= '0;
			ended_q  <= 1'b0;
		end else if (ctrl.data_go) begin
			lbits_q  <= LB_W'(acc & rem_mask);
			lcount_q <= LC_W'(rem);
			ended_q  <= stop;
		end
	end

	assign ended = ended_q;

endmodule

@@ src/fbcu_queue.sv @@
// holds the codes of one byte and hands them out one per beat
module fbcu_queue #(
	parameter int MAX_CODES = 2,
	parameter int LV_W      = 2
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  fbcu_pkg::code_entry_t [MAX_CODES-1:0] lanes,
	input  logic [LV_W-1:0]                       count,
	input  logic                                  pop,
	output fbcu_pkg::code_entry_t                 head,
	output logic                                  head_last,
	output logic [LV_W-1:0]                       level
);

	fbcu_pkg::code_entry_t entries_q [MAX_CODES];
	logic [LV_W-1:0]       level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (load) begin
			level_q <= count;
		end else if (pop) begin
			level_q <= level_q - LV_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < MAX_CODES; k++) begin
				entries_q[k] <= lanes[k];
			end
		end else if (pop) begin
			for (int k = 0; k < MAX_CODES - 1; k++) begin
				entries_q[k] <= entries_q[k + 1];
			end
		end
	end

	assign head      = entries_q[0];
	assign head_last = level_q == LV_W'(1);
	assign level     = level_q;

endmodule

@@ src/five_bit_code_unpacker.sv @@
// top level of the five bit code unpacker
//
//  channel   role    beat contents
//  items     sink    opcode, table_index, table_value, data_byte
//  results   source  out_char, end_mark, last
//
// one result beat per cycle while codes are queued and results are ready; a data byte holds
// the code queue until its codes (1 or 2 at 5-bit codes) are popped, and the next byte can load as the last pops
// first result of a byte comes out through the input reg, the queue and the table read register
// a table load waits in the input register until all queued codes have been looked up
// reset clears the bit carry, end flag and all valid state; the table holds garbage until loaded
// a stalled results channel holds the output register and the table read data
`include "five_bit_code_unpacker_defines.svh"

module five_bit_code_unpacker #(
	parameter int CODE_BITS = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	fbcu_item_if.sink     items,
	fbcu_result_if.source results
);

	localparam int MAX_CODES = (CODE_BITS + 7) / CODE_BITS;
	localparam int LV_W      = $clog2(MAX_CODES + 1);

	// input register
	logic                               valid_s1;
	fbcu_pkg::opcode_t                  op_s1;
	logic [fbcu_pkg::TABLE_AW-1:0]      idx_s1;
	logic [fbcu_pkg::CHAR_W-1:0]        val_s1;
	logic [fbcu_pkg::BYTE_W-1:0]        byte_s1;

	// output register
	logic                               valid_s3;
	logic                               end_s3;
	logic                               last_s3;

	fbcu_pkg::dec_ctrl_t                dctrl;
	fbcu_pkg::code_entry_t [MAX_CODES-1:0] lanes;
	logic [LV_W-1:0]                    dec_count;
	logic                               ended;

	fbcu_pkg::code_entry_t              q_head;
	logic                               q_head_last;
	logic [LV_W-1:0]                    q_level;
	logic                               q_pop;
	logic                               q_free;

	logic                               adv_s1;
	logic                               tbl_we;
	logic [fbcu_pkg::CHAR_W-1:0]        tbl_rdata;

	assign q_pop  = (q_level != '0) && (!valid_s3 || results.ready);
	assign q_free = (q_level == '0) || (q_head_last && q_pop);

	always_comb begin
		adv_s1 = 1'b0;
		if (valid_s1) begin
			case (op_s1)
				fbcu_pkg::OP_LOAD:    adv_s1 = q_level == '0;
				fbcu_pkg::OP_DATA:    adv_s1 = ended || q_free;
				fbcu_pkg::OP_RESTART: adv_s1 = 1'b1;
				default:              adv_s1 = 1'b1;
			endcase
		end
	end

	assign items.ready      = !valid_s1 || adv_s1;
	assign tbl_we           = adv_s1 && (op_s1 == fbcu_pkg::OP_LOAD);
	assign dctrl.data_go    = adv_s1 && (op_s1 == fbcu_pkg::OP_DATA) && !ended;
	assign dctrl.restart_go = adv_s1 && (op_s1 == fbcu_pkg::OP_RESTART);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			op_s1   <= fbcu_pkg::opcode_t'(items.opcode);
			idx_s1  <= items.table_index;
			val_s1  <= items.table_value;
			byte_s1 <= items.data_byte;
		end
	end

	fbcu_decode #(
		.CODE_BITS (CODE_BITS),
		.MAX_CODES (MAX_CODES),
		.LV_W      (LV_W)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (dctrl),
		.data_byte (byte_s1),
		.lanes     (lanes),
		.count     (dec_count),
		.ended     (ended)
	);

	fbcu_queue #(
		.MAX_CODES (MAX_CODES),
		.LV_W      (LV_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (dctrl.data_go),
		.lanes     (lanes),
		.count     (dec_count),
		.pop       (q_pop),
		.head      (q_head),
		.head_last (q_head_last),
		.level     (q_level)
	);

	fbcu_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (idx_s1),
		.wdata (val_s1),
		.re    (q_pop),
		.raddr (q_head.index),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (q_pop) begin
			valid_s3 <= 1'b1;
		end else if (results.ready) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			end_s3  <= q_head.term;
			last_s3 <= q_head_last;
		end
	end

	// terminator beat carries a zero character
	assign results.valid    = valid_s3;
	assign results.out_char = end_s3 ? '0 : tbl_rdata;
	assign results.end_mark = end_s3;
	assign results.last     = last_s3;

	`FBCU_ASSERT_NOW(a_end_is_last, valid_s3 && end_s3, last_s3, "end marker on a beat that is not last")
	`FBCU_ASSERT_NOW(a_load_drained, tbl_we, q_level == '0, "table written while codes still queued")
	`FBCU_ASSERT_NOW(a_level_bound, valid_s1 || !valid_s1, q_level <= LV_W'(MAX_CODES), "queue level overflow")
	`FBCU_ASSERT_NEXT(a_pop_shows, q_pop, valid_s3, "queued code did not reach the output register")

endmodule

@@ bench/fbcu_result_checker.sv @@
// checker for the code unpacker: predicts the characters of each beat and compares results
`timescale 1ns / 100ps

module fbcu_result_checker (
	input  logic   clk,
	input  logic   arst_n,
	fbcu_item_if   items,
	fbcu_result_if results,
	output int     fail_count,
	output int     pending,
	output logic   stream_over
);

	typedef struct packed {
		logic [fbcu_pkg::CHAR_W-1:0] ch;
		logic                        end_mark;
		logic                        last;
	} char_beat_t;

	char_beat_t                  due_chars[$];
	logic [fbcu_pkg::CHAR_W-1:0] char_table [32];
	logic [3:0]                  carry_bits;
	logic [2:0]                  carry_count;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// splits one byte into codes msb first, joining the bits carried from the last byte
	task automatic unpack_byte(input logic [fbcu_pkg::BYTE_W-1:0] data);
		logic [11:0] acc;
		logic [4:0]  code;
		char_beat_t  beats [2];
		int          cnt;
		int          n;
		bit          hit_end;
		cnt = carry_count + 8;
		acc = {carry_bits, data};
		n = 0;
		hit_end = 1'b0;
		while (cnt >= 5 && !hit_end) begin
			cnt -= 5;
			code = 5'((acc >> cnt) & 12'h1F);
			if ({3'b000, code} == fbcu_pkg::END_CODE) begin
				beats[n] = '{ch: '0, end_mark: 1'b1, last: 1'b0};
				stream_over = 1'b1;
				hit_end = 1'b1;
				cnt = 0;
			end else begin
				beats[n] = '{ch: char_table[code], end_mark: 1'b0, last: 1'b0};
			end
			n++;
		end
		carry_count = 3'(cnt);
		carry_bits = 4'(acc & ((12'd1 << cnt) - 12'd1));
		if (n > 0)
			beats[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			due_chars.push_back(beats[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		char_beat_t want;
		if (!arst_n) begin
			carry_bits = '0;
			carry_count = '0;
			stream_over = 1'b0;
			fail_count = 0;
			pending = 0;
			due_chars.delete();
		end else begin
			if (results.valid && results.ready) begin
				if (due_chars.size() == 0) begin
					report_mismatch("unexpected result beat, char", results.out_char, -1);
				end else begin
					want = due_chars.pop_front();
					if (results.out_char !== want.ch)
						report_mismatch("out_char", results.out_char, want.ch);
					if (results.end_mark !== want.end_mark)
						report_mismatch("end_mark", results.end_mark, want.end_mark);
					if (results.last !== want.last)
						report_mismatch("last", results.last, want.last);
				end
			end
			if (items.valid && items.ready) begin
				case (items.opcode)
					fbcu_pkg::OP_LOAD: begin
						char_table[items.table_index] = items.table_value;
					end
					fbcu_pkg::OP_RESTART: begin
						carry_bits = '0;
						carry_count = '0;
						stream_over = 1'b0;
					end
					fbcu_pkg::OP_DATA: begin
						// bytes after the terminator are dropped until a restart
						if (!stream_over) begin
							unpack_byte(items.data_byte);
						end
					end
					default: ;
				endcase
			end
			pending = due_chars.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// top of the code unpacker bench: drives item beats and result stalls, prints the verdict
`timescale 1ns / 100ps

module testbench;

	localparam logic [fbcu_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_BEATS  = 445;
	localparam int SETTLE_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   fail_count;
	int   pending;
	logic stream_over;
	bit   src_calm = 1'b0;
	bit   sink_calm = 1'b0;

	fbcu_item_if   item_ch ();
	fbcu_result_if result_ch ();

	five_bit_code_unpacker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch)
	);

	fbcu_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (item_ch),
		.results     (result_ch),
		.fail_count  (fail_count),
		.pending     (pending),
		.stream_over (stream_over)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int draw_gap(input bit calm);
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(input logic [fbcu_pkg::OPC_W-1:0] opc,
			input logic [fbcu_pkg::TABLE_AW-1:0] idx,
			input logic [fbcu_pkg::CHAR_W-1:0] val, input logic [fbcu_pkg::BYTE_W-1:0] data);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.opcode = opc;
		item_ch.table_index = idx;
		item_ch.table_value = val;
		item_ch.data_byte = data;
		item_ch.valid = 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		if ($urandom_range(0, 39) == 0)
			src_calm = !src_calm;
	endtask

	task automatic send_byte(input logic [fbcu_pkg::BYTE_W-1:0] data);
		send_beat(fbcu_pkg::OP_DATA, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
			data);
	endtask

	task automatic send_plain(input logic [fbcu_pkg::OPC_W-1:0] opc);
		send_beat(opc, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// hold the items channel until every predicted character has come out
	task automatic drain;
		item_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	initial begin
		int gap;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(sink_calm);
			if (gap > 0) begin
				result_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				sink_calm = !sink_calm;
		end
	end

	initial begin
		int          k;
		int          r;
		logic [7:0]  fill;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = fbcu_pkg::OP_LOAD;
		item_ch.table_index = '0;
		item_ch.table_value = '0;
		item_ch.data_byte = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every entry is loaded before any lookup can touch it
		for (k = 0; k < 32; k++) begin
			fill = (k == 0) ? 8'h00 : (k == 30) ? 8'hFF : 8'($urandom_range(0, 255));
			send_beat(fbcu_pkg::OP_LOAD, 5'(k), fill, 8'($urandom_range(0, 255)));
		end

		// terminator as the first code of a fresh five byte group
		send_plain(fbcu_pkg::OP_RESTART);
		repeat (5) send_byte(8'h00);
		send_byte(8'hF8);
		send_byte(8'h3C);
		send_plain(OP_UNUSED);
		// terminator straddling two bytes
		send_plain(fbcu_pkg::OP_RESTART);
		send_byte(8'h07);
		send_byte(8'hC0);
		// code 30 and a reload of its entry
		send_plain(fbcu_pkg::OP_RESTART);
		send_byte(8'hF0);
		send_beat(fbcu_pkg::OP_LOAD, 5'd30, 8'h00, 8'hFF);
		send_byte(8'h7B);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_beat(fbcu_pkg::OP_LOAD, 5'd31, 8'hFF, 8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_plain(fbcu_pkg::OP_RESTART);
		send_plain(OP_UNUSED);
		drain();

		k = 0;
		while (k < RANDOM_BEATS) begin
			r = $urandom_range(0, 99);
			if ((stream_over && r < 60) || r < 5)
				send_plain(fbcu_pkg::OP_RESTART);
			else if (r < 12)
				send_plain(fbcu_pkg::OP_LOAD);
			else if (r < 15)
				send_plain(OP_UNUSED);
			else if ($urandom_range(0, 19) == 0)
				send_byte(8'hFF);
			else
				send_byte(8'($urandom_range(0, 255)));
			k++;
			if (k % 150 == 0)
				drain();
		end

		item_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
